>>> sv/mangled_short_name_hash_assert.svh
// Assertion macros shared by the short-name hash block.
`ifndef MANGLED_SHORT_NAME_HASH_ASSERT_SVH
`define MANGLED_SHORT_NAME_HASH_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and quiet during reset.
`define MNSH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk and quiet during reset.
`define MNSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MNSH_ASSERT_NOW(label, ante, cons)
`define MNSH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/mnsh_pkg.sv
// Types, constants and character functions of the short-name hash block.
package mnsh_pkg;

  localparam logic [15:0] HASH_SEED  = 16'hbeef;
  localparam logic [2:0]  POS_MAX    = 3'd7;
  localparam logic [2:0]  PREFIX_MAX = 3'd4;
  localparam logic [1:0]  EXT_MAX    = 2'd3;
  localparam logic [3:0]  LEN_BASE   = 4'd8;
  localparam logic [3:0]  LEN_EXT    = 4'd9;
  localparam logic [7:0]  CH_TILDE   = 8'h7e;
  localparam logic [7:0]  CH_UNDER   = 8'h5f;
  localparam logic [7:0]  CH_DOT     = 8'h2e;
  localparam logic [7:0]  CH_UP_A    = 8'h41;
  localparam logic [7:0]  CH_UP_Z    = 8'h5a;
  localparam logic [7:0]  CH_LO_A    = 8'h61;
  localparam logic [7:0]  CH_LO_Z    = 8'h7a;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CASE_DIFF  = 8'h20;
  localparam logic [4:0]  ALPHA_LEN  = 5'd26;

  // Snapshot of one finished name, handed from the byte stage to the packer.
  typedef struct packed {
    logic [15:0]     hash;
    logic [7:0]      last_byte;
    logic [3:0][7:0] prefix;
    logic [2:0]      plen;
    logic            dot_seen;
    logic [2:0][7:0] ext;
    logic [1:0]      ext_count;
  } snap_t;

  typedef struct packed {
    logic [63:0] short_head;
    logic [31:0] short_tail;
    logic [3:0]  short_length;
    logic [15:0] hash_value;
  } result_t;

  function automatic logic [7:0] lower_az(input logic [7:0] c);
    lower_az = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_DIFF : c;
  endfunction

  function automatic logic [15:0] sign_ext16(input logic [7:0] c);
    sign_ext16 = {{8{c[7]}}, c};
  endfunction

  function automatic logic [15:0] rotate_mix(input logic [15:0] h);
    rotate_mix = {h[12:0], 3'b000} ^ {5'b00000, h[15:5]};
  endfunction

  // Characters that are not allowed in a short name become an underscore.
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic bad;
    bad = c[7];
    unique case (c)
      8'h2a, 8'h3f, 8'h3c, 8'h3e, 8'h7c, 8'h22, 8'h2b, 8'h3d,
      8'h2c, 8'h3b, 8'h5b, 8'h5d, 8'h20, 8'h7e, 8'h2e, 8'h00: bad = 1'b1;
      default: ;
    endcase
    if (bad) begin
      map_char = CH_UNDER;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      map_char = c - CASE_DIFF;
    end else begin
      map_char = c;
    end
  endfunction

  // Base-32 digit: A to Z, then 0 to 5.
  function automatic logic [7:0] hash_char(input logic [4:0] idx);
    hash_char = (idx < ALPHA_LEN) ? CH_UP_A + {3'b000, idx}
                                  : CH_ZERO + {3'b000, idx - ALPHA_LEN};
  endfunction

endpackage

>>> sv/mnsh_if.sv
// Valid/ready channel interfaces for name bytes and packed short names.
interface mnsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       is_last;
  modport source (output valid, output name_byte, output is_last, input ready);
  modport sink   (input valid, input name_byte, input is_last, output ready);
endinterface

interface mnsh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] short_head;
  logic [31:0] short_tail;
  logic [3:0]  short_length;
  logic [15:0] hash_value;
  modport source (output valid, output short_head, output short_tail,
                  output short_length, output hash_value, input ready);
  modport sink   (input valid, input short_head, input short_tail,
                  input short_length, input hash_value, output ready);
endinterface

>>> sv/mnsh_pack.sv
// Final hash step and 8.3 character packing for one finished name.
module mnsh_pack (
  input  mnsh_pkg::snap_t   snap,
  output mnsh_pkg::result_t res
);

  logic [15:0]      hash_fin;
  logic [11:0][7:0] chars;

  always_comb begin
    hash_fin = mnsh_pkg::rotate_mix(snap.hash)
             ^ mnsh_pkg::sign_ext16(mnsh_pkg::lower_az(snap.last_byte));
    chars = '0;
    for (int k = 0; k < 4; k++) begin
      chars[k] = (3'(k) < snap.plen) ? mnsh_pkg::map_char(snap.prefix[k])
                                     : mnsh_pkg::CH_TILDE;
    end
    chars[4] = mnsh_pkg::CH_TILDE;
    chars[5] = mnsh_pkg::hash_char(hash_fin[14:10]);
    chars[6] = mnsh_pkg::hash_char(hash_fin[9:5]);
    chars[7] = mnsh_pkg::hash_char(hash_fin[4:0]);
    if (snap.dot_seen) begin
      chars[8] = mnsh_pkg::CH_DOT;
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < snap.ext_count) begin
          chars[9 + k] = mnsh_pkg::map_char(snap.ext[k]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      res.short_head[8*k +: 8] = chars[k];
    end
    for (int k = 0; k < 4; k++) begin
      res.short_tail[8*k +: 8] = chars[8 + k];
    end
    res.short_length = snap.dot_seen ? mnsh_pkg::LEN_EXT + {2'b00, snap.ext_count}
                                     : mnsh_pkg::LEN_BASE;
    res.hash_value   = hash_fin;
  end

endmodule

>>> sv/mangled_short_name_hash.sv
// Top level of the hashed 8.3 short-name generator.
//
// The block takes a long file name on in_ch, one byte per transfer, first
// byte first, with is_last high on the final byte. Every name has at least
// one byte. For each name it returns one transfer on out_ch holding the
// short name PPPP~HHH.EEE packed into short_head and short_tail, its length
// in characters and the 16-bit hash of the long name.
// Each byte updates the running hash, the prefix and extension stores in the
// cycle of its transfer, so a byte can be taken every cycle. The final byte
// also copies the finished state into a snapshot register; the packer then
// does the last hash step and character mapping into the result register.
// A result becomes valid on out_ch once the result register has loaded it.
// When the receiver stalls, one result waits in the output register and one
// more in the snapshot register; bytes keep flowing until both are full,
// and only then does in_ch.ready drop.
// After reset (rst_n low at a clock edge) the hash holds its seed 16'hbeef,
// all counters and flags are clear and no result is pending. The same clean
// name state is restored after every final byte.
`include "mangled_short_name_hash_assert.svh"

module mangled_short_name_hash (
  input  logic              clk,
  input  logic              rst_n,
  mnsh_in_if.sink           in_ch,
  mnsh_out_if.source        out_ch
);

  // Per-name state, updated on every byte transfer.
  logic [15:0]     hash_r;
  logic [7:0]      held_r;
  logic [2:0]      pos_r;
  logic [3:0][7:0] prefix_r;
  logic            dot_r;
  logic [2:0]      dot_place_r;
  logic [2:0][7:0] ext_r;
  logic [1:0]      ext_cnt_r;

  // Pipeline registers behind the byte stage.
  logic                pend_v_r;
  mnsh_pkg::snap_t     pend_r;
  logic                out_v_r;
  mnsh_pkg::result_t   out_r;

  logic                in_acc;
  logic                out_load;
  logic [7:0]          b;
  logic                dot_start;
  logic                ext_wr;
  logic [15:0]         hash_nxt;
  logic [2:0]          pos_nxt;
  logic [3:0][7:0]     prefix_nxt;
  logic [2:0][7:0]     ext_nxt;
  logic [1:0]          ext_cnt_nxt;
  logic [2:0]          dot_place_nxt;
  logic [2:0]          plen;
  mnsh_pkg::snap_t     snap_nxt;
  mnsh_pkg::result_t   packed_res;

  // The result register loads when the snapshot is full and the register
  // is either empty or being drained this cycle.
  assign out_load     = pend_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !pend_v_r || out_load;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.name_byte;

  // A dot opens an extension unless it is the first or the final byte.
  assign dot_start = (b == mnsh_pkg::CH_DOT) && (pos_r != 3'd0) && !in_ch.is_last;
  assign ext_wr    = !dot_start && dot_r && (ext_cnt_r < mnsh_pkg::EXT_MAX);

  always_comb begin
    prefix_nxt = prefix_r;
    if (pos_r < mnsh_pkg::PREFIX_MAX) begin
      prefix_nxt[pos_r[1:0]] = b;
    end
    ext_nxt     = ext_r;
    ext_cnt_nxt = ext_cnt_r;
    if (dot_start) begin
      ext_cnt_nxt = 2'd0;
    end else if (ext_wr) begin
      ext_nxt[ext_cnt_r] = b;
      ext_cnt_nxt        = ext_cnt_r + 2'd1;
    end
    dot_place_nxt = (pos_r < mnsh_pkg::PREFIX_MAX) ? pos_r : mnsh_pkg::PREFIX_MAX;

    // Pair step: earlier byte sign-extended in the low half, this byte high.
    if (pos_r != 3'd0) begin
      hash_nxt = mnsh_pkg::rotate_mix(hash_r)
               ^ mnsh_pkg::sign_ext16(mnsh_pkg::lower_az(held_r))
               ^ {mnsh_pkg::lower_az(b), 8'h00};
    end else begin
      hash_nxt = hash_r;
    end
    pos_nxt = (pos_r == mnsh_pkg::POS_MAX) ? pos_r : pos_r + 3'd1;

    // Prefix length: up to four bytes, cut at the extension dot. A final
    // byte never opens an extension, so the current dot state applies.
    plen = (pos_nxt < mnsh_pkg::PREFIX_MAX) ? pos_nxt : mnsh_pkg::PREFIX_MAX;
    if (dot_r && (dot_place_r < plen)) begin
      plen = dot_place_r;
    end

    snap_nxt.hash      = hash_nxt;
    snap_nxt.last_byte = b;
    snap_nxt.prefix    = prefix_nxt;
    snap_nxt.plen      = plen;
    snap_nxt.dot_seen  = dot_r;
    snap_nxt.ext       = ext_nxt;
    snap_nxt.ext_count = ext_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= mnsh_pkg::HASH_SEED;
      held_r      <= 8'h00;
      pos_r       <= 3'd0;
      dot_r       <= 1'b0;
      dot_place_r <= 3'd0;
      ext_cnt_r   <= 2'd0;
    end else if (in_acc) begin
      if (in_ch.is_last) begin
        hash_r      <= mnsh_pkg::HASH_SEED;
        held_r      <= 8'h00;
        pos_r       <= 3'd0;
        dot_r       <= 1'b0;
        dot_place_r <= 3'd0;
        ext_cnt_r   <= 2'd0;
      end else begin
        hash_r    <= hash_nxt;
        held_r    <= b;
        pos_r     <= pos_nxt;
        ext_cnt_r <= ext_cnt_nxt;
        if (dot_start) begin
          dot_r       <= 1'b1;
          dot_place_r <= dot_place_nxt;
        end
      end
    end
  end

  // Stores read only after being written for the current name.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prefix_r <= prefix_nxt;
      ext_r    <= ext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_acc && in_ch.is_last) begin
      pend_v_r <= 1'b1;
    end else if (out_load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.is_last) begin
      pend_r <= snap_nxt;
    end
  end

  mnsh_pack u_pack (
    .snap (pend_r),
    .res  (packed_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= packed_res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.short_head   = out_r.short_head;
  assign out_ch.short_tail   = out_r.short_tail;
  assign out_ch.short_length = out_r.short_length;
  assign out_ch.hash_value   = out_r.hash_value;

  // A final byte always leaves a pending snapshot and a clean name state.
  `MNSH_ASSERT_NEXT(a_last_pends, in_acc && in_ch.is_last, pend_v_r)
  `MNSH_ASSERT_NEXT(a_last_clears, in_acc && in_ch.is_last,
                    pos_r == 3'd0 && !dot_r && hash_r == mnsh_pkg::HASH_SEED)
  // A pending snapshot that cannot move on is not dropped.
  `MNSH_ASSERT_NEXT(a_pend_kept, pend_v_r && !out_load, pend_v_r)
  // The dot position never exceeds the prefix width.
  `MNSH_ASSERT_NOW(a_dot_place, 1'b1, dot_place_r <= mnsh_pkg::PREFIX_MAX)
  // A result carries either no extension or a dot with up to three bytes.
  `MNSH_ASSERT_NOW(a_len_legal, out_v_r,
                   out_r.short_length == 4'd8 || out_r.short_length == 4'd9 ||
                   out_r.short_length == 4'd10 || out_r.short_length == 4'd11 ||
                   out_r.short_length == 4'd12)

endmodule

>>> verif/mangled_short_name_hash_checker.sv
`timescale 1ns / 100ps
// Checker for the short-name hash block: predicts each packed short name and compares it.
module mangled_short_name_hash_checker (
  input  logic clk,
  input  logic rst_n,
  mnsh_in_if   in_mon,
  mnsh_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  // Predicted state of the name being collected.
  logic [15:0] nm_hash;
  logic [7:0]  nm_held;
  logic [2:0]  nm_pos;
  logic [7:0]  pre_b [4];
  logic        dot_on;
  logic [2:0]  dot_at;
  logic [7:0]  ext_b [3];
  logic [1:0]  ext_n;

  mnsh_pkg::result_t expected_names [$];
  int                mismatches = 0;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= mnsh_pkg::CH_UP_A && c <= mnsh_pkg::CH_UP_Z) ?
                c + mnsh_pkg::CASE_DIFF : c;
  endfunction

  function automatic logic [15:0] widen_signed(input logic [7:0] c);
    widen_signed = c[7] ? {8'hff, c} : {8'h00, c};
  endfunction

  function automatic logic [15:0] mix_rot(input logic [15:0] h);
    mix_rot = (h << 3) ^ (h >> 5);
  endfunction

  // Characters not allowed in a short name turn into an underscore.
  function automatic logic [7:0] legal_char(input logic [7:0] c);
    case (c)
      8'h2a, 8'h3f, 8'h3c, 8'h3e, 8'h7c, 8'h22, 8'h2b, 8'h3d,
      8'h2c, 8'h3b, 8'h5b, 8'h5d, 8'h20, mnsh_pkg::CH_TILDE, mnsh_pkg::CH_DOT, 8'h00:
        legal_char = mnsh_pkg::CH_UNDER;
      default:
        if (c[7]) begin
          legal_char = mnsh_pkg::CH_UNDER;
        end else if (c >= mnsh_pkg::CH_LO_A && c <= mnsh_pkg::CH_LO_Z) begin
          legal_char = c - mnsh_pkg::CASE_DIFF;
        end else begin
          legal_char = c;
        end
    endcase
  endfunction

  function automatic logic [7:0] base32_digit(input logic [4:0] d);
    if (d < 5'd26) begin
      base32_digit = mnsh_pkg::CH_UP_A + 8'(d);
    end else begin
      base32_digit = mnsh_pkg::CH_ZERO + 8'(d - 5'd26);
    end
  endfunction

  task automatic clear_name();
    nm_hash = mnsh_pkg::HASH_SEED;
    nm_held = 8'h00;
    nm_pos  = 3'd0;
    dot_on  = 1'b0;
    dot_at  = 3'd0;
    ext_n   = 2'd0;
  endtask

  // Folds one name byte into the prediction; the final byte yields a short name.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [7:0]        chars [12];
    int                n;
    int                plen;
    int                k;
    mnsh_pkg::result_t r;
    n = 0;
    if (nm_pos < 4) pre_b[nm_pos[1:0]] = b;
    if (b == mnsh_pkg::CH_DOT && nm_pos >= 1 && !last) begin
      dot_on = 1'b1;
      dot_at = (nm_pos < 4) ? nm_pos : 3'd4;
      ext_n  = 2'd0;
    end else if (dot_on && ext_n < 3) begin
      ext_b[ext_n] = b;
      ext_n++;
    end
    if (nm_pos > 0) begin
      nm_hash = mix_rot(nm_hash) ^ widen_signed(fold_case(nm_held)) ^ {fold_case(b), 8'h00};
    end
    nm_held = b;
    if (nm_pos < 7) nm_pos++;
    if (last) begin
      nm_hash = mix_rot(nm_hash) ^ widen_signed(fold_case(b));
      plen = (nm_pos < 4) ? nm_pos : 4;
      if (dot_on && dot_at < plen) plen = dot_at;
      for (k = 0; k < plen; k++) begin
        chars[n] = legal_char(pre_b[k]);
        n++;
      end
      while (n < 5) begin
        chars[n] = mnsh_pkg::CH_TILDE;
        n++;
      end
      chars[5] = base32_digit(nm_hash[14:10]);
      chars[6] = base32_digit(nm_hash[9:5]);
      chars[7] = base32_digit(nm_hash[4:0]);
      n = 8;
      if (dot_on) begin
        chars[n] = mnsh_pkg::CH_DOT;
        n++;
        for (k = 0; k < ext_n; k++) begin
          chars[n] = legal_char(ext_b[k]);
          n++;
        end
      end
      r = '0;
      for (k = 0; k < 8; k++) r.short_head[8*k +: 8] = chars[k];
      for (k = 8; k < n; k++) r.short_tail[8*(k-8) +: 8] = chars[k];
      r.short_length = 4'(n);
      r.hash_value   = nm_hash;
      expected_names.insert(expected_names.size(), r);
      clear_name();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: short name mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    mnsh_pkg::result_t want;
    if (expected_names.size() == 0) begin
      report_mismatch("result with no name pending", out_mon.short_head, '0);
      return;
    end
    want = expected_names.pop_front();
    if (out_mon.short_head !== want.short_head)
      report_mismatch("short_head", out_mon.short_head, want.short_head);
    if (out_mon.short_tail !== want.short_tail)
      report_mismatch("short_tail", 64'(out_mon.short_tail), 64'(want.short_tail));
    if (out_mon.short_length !== want.short_length)
      report_mismatch("short_length", 64'(out_mon.short_length), 64'(want.short_length));
    if (out_mon.hash_value !== want.hash_value)
      report_mismatch("hash_value", 64'(out_mon.hash_value), 64'(want.hash_value));
  endtask

  // Byte transfers are folded in before result transfers of the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      expected_names.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_byte(in_mon.name_byte, in_mon.is_last);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending    <= expected_names.size();
    fail_count <= mismatches;
  end

endmodule

>>> verif/mangled_short_name_hash_tb.sv
`timescale 1ns / 100ps
// Testbench top for the short-name hash block: stimulus, result-side stalls and verdict.
module mangled_short_name_hash_tb;

  // Longest stretch without any transfer before the run is called hung. The
  // slowest correct stretch is a long receiver hold-off plus a sender gap.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BYTES = 1150;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mnsh_in_if  in_ch ();
  mnsh_out_if out_ch ();

  int fail_count;
  int pending;
  int bytes_taken = 0;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;

  // Bytes of the name that is about to be sent, first byte first.
  logic [7:0] name_q [$];

  mangled_short_name_hash DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mangled_short_name_hash_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: any transfer on either channel restarts the idle count. It also
  // counts accepted bytes, which the result side uses to time its hold-offs.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (in_ch.valid && in_ch.ready) bytes_taken <= bytes_taken + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[mangled_short_name_hash] ERROR");
      $finish;
    end
  end

  // Draws a name byte. Letters of both cases, digits and dots dominate so that
  // names look real, while forbidden characters, high bytes and zero bytes
  // still show up often enough to exercise the character mapping.
  function automatic logic [7:0] pick_name_char();
    case ($urandom_range(0, 9))
      0, 1: pick_name_char = mnsh_pkg::CH_UP_A + 8'($urandom_range(0, 25));
      2, 3: pick_name_char = mnsh_pkg::CH_LO_A + 8'($urandom_range(0, 25));
      4:    pick_name_char = mnsh_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      5:    pick_name_char = mnsh_pkg::CH_DOT;
      6:    pick_name_char = 8'($urandom_range(32, 127));
      7:    pick_name_char = 8'($urandom_range(0, 255));
      8:    pick_name_char = 8'($urandom_range(128, 255));
      default:
        case ($urandom_range(0, 3))
          0:       pick_name_char = 8'h00;
          1:       pick_name_char = mnsh_pkg::CH_TILDE;
          2:       pick_name_char = 8'h20;
          default: pick_name_char = mnsh_pkg::CH_UNDER;
        endcase
    endcase
  endfunction

  // Offers one byte and waits for its transfer. The sender works in bursts:
  // when a burst runs out, valid drops for a short random gap. Most bursts are
  // short so gaps land on every byte position of a name; some are long and
  // give stretches with no idling at all.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.name_byte <= b;
    in_ch.is_last   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_name();
    foreach (name_q[i]) push_byte(name_q[i], i == name_q.size() - 1);
    name_q.delete();
  endtask

  // Appends one byte to the name being built.
  task automatic add_byte(input logic [7:0] b);
    name_q.insert(name_q.size(), b);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i]);
  endtask

  // Result side. Ready follows a pattern drawn anew for each random span:
  // always ready, coin flips, a repeating 16-bit mask, or rare stalls. Twice
  // during the run it holds off for a long stretch while the sender keeps
  // offering bytes, so both result slots fill and the byte input stalls.
  initial begin : result_side
    int          mode;
    int          span;
    int          phase;
    int          hold;
    bit          first_hold_done;
    bit          second_hold_done;
    logic [15:0] mask;
    hold             = 0;
    phase            = 0;
    first_hold_done  = 1'b0;
    second_hold_done = 1'b0;
    out_ch.ready     = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      mask = 16'($urandom);
      span = $urandom_range(16, 96);
      repeat (span) begin
        if (!first_hold_done && bytes_taken >= 300) begin
          first_hold_done = 1'b1;
          hold = HOLD_CYCLES;
        end else if (!second_hold_done && bytes_taken >= 800) begin
          second_hold_done = 1'b1;
          hold = HOLD_CYCLES;
        end
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          hold--;
        end else begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= mask[phase % 16];
            default: out_ch.ready <= ($urandom_range(0, 9) != 0);
          endcase
        end
        phase++;
        @(posedge clk);
      end
    end
  end

  initial begin : name_side
    int len;
    int shape;
    in_ch.valid     = 1'b0;
    in_ch.name_byte = 8'h00;
    in_ch.is_last   = 1'b0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names. One-byte names: all ones, a lone dot and a zero byte.
    add_byte(8'hff);
    send_name();
    add_byte(mnsh_pkg::CH_DOT);
    send_name();
    add_byte(8'h00);
    send_name();
    // A leading dot never opens an extension.
    add_text(".aZ");
    send_name();
    // A dot in the last byte lands in the open extension as an underscore.
    add_text("q.z.");
    send_name();
    // Boundary bytes either side of the sign bit.
    add_byte(8'h80);
    add_byte(8'h7f);
    send_name();
    // Long name: position saturates, dot beyond the prefix, extension cut to three.
    add_text("abcdefg.hijk");
    send_name();

    // Random names. Most are short; some are long enough to saturate the
    // counters. Many get a dot planted inside so that they carry an
    // extension; a few end in a dot.
    while (bytes_sent < RANDOM_BYTES) begin
      shape = $urandom_range(0, 9);
      len   = (shape == 0) ? $urandom_range(15, 40) : $urandom_range(1, 12);
      repeat (len) add_byte(pick_name_char());
      if (shape >= 5 && len >= 3) name_q[$urandom_range(1, len - 2)] = mnsh_pkg::CH_DOT;
      if (shape == 4) name_q[len - 1] = mnsh_pkg::CH_DOT;
      send_name();
    end
    in_ch.valid <= 1'b0;

    // Wait for the last short name to come out; the watchdog bounds this.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[mangled_short_name_hash] OK");
    end else begin
      $display("[mangled_short_name_hash] ERROR");
    end
    $finish;
  end

endmodule

>>> mangled_short_name_hash.f
+incdir+sv
sv/mnsh_pkg.sv
sv/mnsh_if.sv
sv/mnsh_pack.sv
sv/mangled_short_name_hash.sv
verif/mangled_short_name_hash_checker.sv
verif/mangled_short_name_hash_tb.sv
